[sv/lzss_pkg.sv]
// Shared types and constants of the LZSS decompressor.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package lzss_pkg;

	// Default history window size in bytes.
	localparam int WINDOW_SIZE_DEF = 4096;

	// Window positions that a stream starts writing before the window end.
	localparam int START_BACKOFF = 18;

	// Byte that every window position reads as after reset and after a stream ends.
	localparam logic [7:0] FILL_BYTE = 8'h20;

	// Number of tokens announced by one flag byte.
	localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

	// A match copies its length nibble plus this many bytes.
	localparam logic [4:0] MATCH_MIN = 5'd3;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_LIT,
		S_RD,
		S_EMIT
	} state_t;

endpackage

[sv/lzss_in_if.sv]
// Input channel of the LZSS decompressor: one compressed byte per item.
// Plain valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface lzss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_end;

	modport source (output valid, in_byte, stream_end, input ready);
	modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

[sv/lzss_out_if.sv]
// Output channel of the LZSS decompressor: one decompressed byte per item.
// Plain valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface lzss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink   (input valid, out_byte, run_last, output ready);
endinterface

[sv/lzss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the history window.
`timescale 1ns / 1ps

module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/lzss_decompressor_core.sv]
// LZSS decompressor top level with a 4096-byte history window.
// Depends on lzss_pkg, lzss_in_if, lzss_out_if and lzss_ram.
`timescale 1ns / 1ps
//
// Usage:
// The in_ch channel takes one compressed byte per item, with stream_end high
// on the final byte of a stream. The out_ch channel delivers decompressed
// bytes; run_last is high on the last byte caused by one input item.
// A flag byte or the first byte of a match gives no output. A literal is
// emitted and written back from the literal state. The second byte of a match
// of length L (3 to 18) runs the read and emit states in turn for each copied
// byte: the read state reads the window through the registered read port of
// the history RAM, and the emit state emits the byte and writes it back.
// in_ch.ready is high only while the sequencer is idle.
// Reset (and the end of a stream) returns the write position to 4078 and the
// token state to zero. The window is not swept: a fill count records how many
// bytes have been written since, and any position not yet written reads as a
// space. Hence there is no clearing pass and the block is ready at once.
// A stalled receiver holds the output register; the sequencer waits with it
// and loses nothing.
//

module lzss_decompressor_core #(
	parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lzss_in_if.sink           in_ch,
	lzss_out_if.source        out_ch
);

	import lzss_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - START_BACKOFF);
	localparam logic [AW:0]   FILL_FULL = (AW + 1)'(WINDOW_SIZE);

	state_t state_q, state_d;

	// Token state.
	logic [7:0]    flag_bits_q;
	logic [3:0]    flags_left_q;
	logic          phase_q;
	logic [7:0]    offset_low_q;
	logic [7:0]    lit_q;
	logic          last_q;

	// Window bookkeeping.
	logic [AW-1:0] wpos_q;
	logic [AW:0]   fill_q;
	logic [AW-1:0] rd_q;
	logic [4:0]    cnt_q;
	logic          hit_s1;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          run_last_q;

	// Sequencer outputs.
	logic          accept;
	logic          slot_free;
	logic          out_load;
	logic [7:0]    out_data;
	logic          out_last;
	logic          ram_we;
	logic          ram_re;
	logic          do_clear;
	logic [7:0]    ram_rdata;
	logic [AW-1:0] rd_dist;
	logic          rd_written;

	lzss_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_SIZE)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q),
		.wdata (out_data),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	assign accept    = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;

	// A position holds real data only if it lies within the bytes written since the
	// last clear, counted forward from the start position.
	assign rd_dist    = rd_q - START_POS;
	assign rd_written = ({1'b0, rd_dist} < fill_q);

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		out_data    = lit_q;
		out_last    = 1'b1;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		do_clear    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (flags_left_q == '0) begin
						do_clear = 1'b0;
						state_d  = S_IDLE;
					end else if (flag_bits_q[0]) begin
						state_d = S_LIT;
					end else if (phase_q) begin
						state_d = S_RD;
					end
					// Tokens that give no output end the stream right away.
					if (in_ch.stream_end && state_d == S_IDLE) begin
						do_clear = 1'b1;
					end
				end
			end
			S_LIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					ram_we   = 1'b1;
					do_clear = last_q;
					state_d  = S_IDLE;
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				out_data = hit_s1 ? ram_rdata : FILL_BYTE;
				out_last = (cnt_q == '0);
				if (slot_free) begin
					out_load = 1'b1;
					ram_we   = 1'b1;
					if (cnt_q == '0) begin
						do_clear = last_q;
						state_d  = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			phase_q      <= 1'b0;
			offset_low_q <= '0;
			last_q       <= 1'b0;
			wpos_q       <= START_POS;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				last_q <= in_ch.stream_end;
				if (flags_left_q == '0) begin
					flag_bits_q  <= in_ch.in_byte;
					flags_left_q <= FLAGS_PER_BYTE;
					phase_q      <= 1'b0;
				end else if (flag_bits_q[0] || phase_q) begin
					// Literal or second match byte: this token is done.
					flag_bits_q  <= {1'b0, flag_bits_q[7:1]};
					flags_left_q <= flags_left_q - 4'd1;
					phase_q      <= 1'b0;
				end else begin
					offset_low_q <= in_ch.in_byte;
					phase_q      <= 1'b1;
				end
			end
			if (ram_we) begin
				wpos_q <= wpos_q + 1'b1;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_clear) begin
				flag_bits_q  <= '0;
				flags_left_q <= '0;
				phase_q      <= 1'b0;
				offset_low_q <= '0;
				wpos_q       <= START_POS;
				fill_q       <= '0;
			end
		end
	end

	// Payload registers of the copy loop and the output stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q <= in_ch.in_byte;
			rd_q  <= AW'({in_ch.in_byte[7:4], offset_low_q});
			cnt_q <= {1'b0, in_ch.in_byte[3:0]} + MATCH_MIN - 5'd1;
		end
		if (ram_re) begin
			hit_s1 <= rd_written;
			rd_q   <= rd_q + 1'b1;
		end
		if (state_q == S_EMIT && out_load && cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
		if (out_load) begin
			out_byte_q <= out_data;
			run_last_q <= out_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;

	// The fill count saturates at the window size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond window size");

	// A window read is always followed by the emit step that consumes it.
	a_rd_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_EMIT))
		else $error("window read not followed by emit");

	// The last byte of a match returns the sequencer to idle.
	a_match_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_load && cnt_q == '0) |=> (state_q == S_IDLE))
		else $error("match did not end after its last byte");

	// The output register is never loaded while a stalled receiver still holds its byte.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !out_load)
		else $error("output register overwritten while stalled");

endmodule

[test/lzss_decompressor_core_test.sv]
// Self-checking testbench of the LZSS decompressor core (4096-byte window).
// Depends on lzss_pkg, lzss_in_if, lzss_out_if and the lzss_decompressor_core RTL.
`timescale 1ns / 1ps

module lzss_decompressor_core_test;
	import lzss_pkg::*;

	// One decompressed byte as it should appear on the output channel.
	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} out_item_t;

	// One row of the directed table. A typed count of -1 means that the
	// expected bytes come from the decoder model below. Otherwise the row
	// expects that many copies of the typed byte.
	typedef struct {
		logic [7:0] code;
		logic       term;
		int         n_typed;
		logic [7:0] typed;
	} plan_row_t;

	// One compressed byte of a random stream, before it is sent.
	typedef struct {
		logic [7:0] code;
		logic       term;
	} stream_item_t;

	localparam int          N_PLAN     = 21;
	localparam int          N_ITEMS    = 410;
	localparam int          CALM_AFTER = 340;
	localparam logic [11:0] START_POS  = 12'(WINDOW_SIZE_DEF - START_BACKOFF);

	logic clk;
	logic arst_n;

	lzss_in_if  in_ch ();
	lzss_out_if out_ch ();

	lzss_decompressor_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Decoder model state: history window, write position and token state.
	logic [7:0]  window_mem [WINDOW_SIZE_DEF];
	logic [11:0] wr_pos;
	logic [7:0]  flag_reg;
	logic [3:0]  tokens_left;
	logic        match_half;
	logic [7:0]  pos_low;

	// Bytes produced by the most recent compressed byte, and every byte
	// still owed by the block, oldest first.
	out_item_t run_q [$];
	out_item_t expected_out [$];

	int errors      = 0;
	int items_sent  = 0;
	int bytes_seen  = 0;
	int streams     = 0;
	int cut_streams = 0;

	// Idling controls, changed from stream to stream by the stimulus.
	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	bit calm          = 0;

	// Directed part. It covers literals of 0x00 and 0xFF, the shortest and
	// longest match, a match at the top of the window that wraps around, an
	// overlapping copy that reads bytes it has just written, and the end of a
	// stream on a flag byte, on a literal, on the second byte of a match and
	// in the middle of a match. The last row proves that the end of a stream
	// refills the window with spaces.
	plan_row_t plan [N_PLAN] = '{
		'{8'h5C, 1'b0,  0, 8'h00},  // flags: match, match, 3 literals, ...
		'{8'h00, 1'b0,  0, 8'h00},
		'{8'hF0, 1'b0,  3, 8'h20},  // shortest match, window still spaces
		'{8'hFF, 1'b0,  0, 8'h00},
		'{8'hFF, 1'b0, 18, 8'h20},  // longest match from 0xFFF, wraps
		'{8'h00, 1'b0,  1, 8'h00},
		'{8'hFF, 1'b0,  1, 8'hFF},
		'{8'hA5, 1'b0,  1, 8'hA5},
		'{8'h03, 1'b0,  0, 8'h00},
		'{8'h01, 1'b0, -1, 8'h00},  // overlapping copy of the fresh literals
		'{8'h3C, 1'b0,  1, 8'h3C},
		'{8'h34, 1'b1,  0, 8'h00},  // stream ends with half a match pending
		'{8'hFF, 1'b0,  0, 8'h00},
		'{8'h81, 1'b1,  1, 8'h81},  // stream ends on a literal
		'{8'h00, 1'b1,  0, 8'h00},  // stream ends on a flag byte
		'{8'hFE, 1'b0,  0, 8'h00},
		'{8'hEE, 1'b0,  0, 8'h00},
		'{8'h0F, 1'b1, 18, 8'h20},  // stream ends on a full match
		'{8'h00, 1'b0,  0, 8'h00},
		'{8'h03, 1'b0,  0, 8'h00},
		'{8'h00, 1'b1,  3, 8'h20}   // old literals at 3..5 must be gone
	};

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	// Returns the window and the token state to their state after reset.
	function automatic void clear_window();
		for (int i = 0; i < WINDOW_SIZE_DEF; i++) begin
			window_mem[i] = FILL_BYTE;
		end
		wr_pos      = START_POS;
		flag_reg    = '0;
		tokens_left = '0;
		match_half  = 1'b0;
		pos_low     = '0;
	endfunction

	// Emits one decoded byte and writes it back into the history window.
	function automatic void put_byte(input logic [7:0] data);
		out_item_t item;

		item.data = data;
		item.tail = 1'b0;
		run_q.push_back(item);
		window_mem[wr_pos] = data;
		wr_pos = wr_pos + 12'd1;
	endfunction

	function automatic void next_token();
		flag_reg    = flag_reg >> 1;
		tokens_left = tokens_left - 4'd1;
		match_half  = 1'b0;
	endfunction

	// Decodes one compressed byte into run_q, as the block must.
	function automatic void decode_byte(input logic [7:0] code, input logic term);
		logic [11:0] src;
		int          n;

		run_q.delete();
		if (tokens_left == 4'd0) begin
			flag_reg    = code;
			tokens_left = FLAGS_PER_BYTE;
			match_half  = 1'b0;
		end else if (flag_reg[0]) begin
			put_byte(code);
			next_token();
		end else if (!match_half) begin
			pos_low    = code;
			match_half = 1'b1;
		end else begin
			// The copy reads one byte at a time, so a source that overlaps
			// the write position repeats bytes written by this same copy.
			src = {code[7:4], pos_low};
			n   = int'(code[3:0]) + int'(MATCH_MIN);
			for (int k = 0; k < n; k++) begin
				put_byte(window_mem[src + 12'(k)]);
			end
			next_token();
		end
		if (run_q.size() > 0) begin
			run_q[run_q.size() - 1].tail = 1'b1;
		end
		if (term) begin
			clear_window();
		end
	endfunction

	// Offers one compressed byte, after a random gap when idling is on, and
	// waits until the block takes it. When from_model is set, the bytes it causes are then owed.
	task automatic send_code(input logic [7:0] code, input logic term, input bit from_model);
		if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.in_byte    <= code;
		in_ch.stream_end <= term;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		items_sent++;
		decode_byte(code, term);
		if (from_model) begin
			foreach (run_q[i]) begin
				expected_out.push_back(run_q[i]);
			end
		end
	endtask

	// Builds one random stream from well-formed flag groups with random
	// content. Match sources are either just behind the write position, so
	// that copies overlap and repeat recent bytes, or anywhere in the window.
	// A few streams are plain noise, and a few are cut short at a random byte.
	task automatic play_stream();
		stream_item_t burst [$];
		stream_item_t item;
		logic [11:0]  gen_pos;
		logic [11:0]  src;
		logic [7:0]   flags;
		logic [3:0]   len_nib;
		int           groups;
		int           cut;

		gen_pos = wr_pos;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(5, 30)) begin
				item.code = 8'($urandom_range(0, 255));
				item.term = 1'b0;
				burst.push_back(item);
			end
		end else begin
			groups = $urandom_range(1, 4);
			repeat (groups) begin
				flags     = 8'($urandom_range(0, 255));
				item.term = 1'b0;
				item.code = flags;
				burst.push_back(item);
				for (int t = 0; t < 8; t++) begin
					if (flags[t]) begin
						item.code = 8'($urandom_range(0, 255));
						burst.push_back(item);
						gen_pos = gen_pos + 12'd1;
					end else begin
						len_nib = 4'($urandom_range(0, 15));
						if ($urandom_range(0, 1) == 0) begin
							src = gen_pos - 12'($urandom_range(1, 20));
						end else begin
							src = 12'($urandom_range(0, WINDOW_SIZE_DEF - 1));
						end
						item.code = src[7:0];
						burst.push_back(item);
						item.code = {src[11:8], len_nib};
						burst.push_back(item);
						gen_pos = gen_pos + 12'(len_nib) + 12'(MATCH_MIN);
					end
				end
			end
		end
		cut = burst.size() - 1;
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(0, burst.size() - 1);
			cut_streams++;
		end
		burst[cut].term = 1'b1;
		for (int i = 0; i <= cut; i++) begin
			send_code(burst[i].code, burst[i].term, 1'b1);
		end
		streams++;
	endtask

	// Receiver: ready drops in random bursts while stalls are enabled.
	initial begin
		int hold;

		hold = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
				hold = $urandom_range(1, 10) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Every byte taken from the block is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			bytes_seen++;
			if (expected_out.size() == 0) begin
				$error("unexpected output byte: out_byte 0x%02h run_last %0b",
					out_ch.out_byte, out_ch.run_last);
				errors++;
			end else begin
				if (out_ch.out_byte !== expected_out[0].data) begin
					$error("out_byte: expected 0x%02h, got 0x%02h",
						expected_out[0].data, out_ch.out_byte);
					errors++;
				end
				if (out_ch.run_last !== expected_out[0].tail) begin
					$error("run_last: expected %0b, got %0b",
						expected_out[0].tail, out_ch.run_last);
					errors++;
				end
				void'(expected_out.pop_front());
			end
		end
	end

	// A slow but correct run finishes well before this timeout.
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		out_item_t item;

		clear_window();
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.in_byte    <= '0;
		in_ch.stream_end <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: typed rows owe their typed bytes, the rest owe
		// what the decoder model produces.
		in_idle_pct   = 30;
		out_stall_pct = 30;
		foreach (plan[r]) begin
			send_code(plan[r].code, plan[r].term, plan[r].n_typed < 0);
			for (int i = 0; i < plan[r].n_typed; i++) begin
				item.data = plan[r].typed;
				item.tail = (i == plan[r].n_typed - 1);
				expected_out.push_back(item);
			end
		end

		// Random streams, with idling settings that change from stream to
		// stream and none at all near the end.
		while (items_sent < N_ITEMS) begin
			case ($urandom_range(0, 2))
				0: begin
					in_idle_pct   = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct   = 15;
					out_stall_pct = 20;
				end
				default: begin
					in_idle_pct   = 40;
					out_stall_pct = 50;
				end
			endcase
			calm = (items_sent >= CALM_AFTER);
			play_stream();
		end
		in_ch.valid <= 1'b0;

		while (expected_out.size() != 0) begin
			@(posedge clk);
		end
		// A match ahead of us would still be draining; give stray bytes
		// time to show up.
		repeat (50) @(posedge clk);

		$display("Decoded %0d compressed bytes in %0d random streams (%0d cut short).",
			items_sent, streams, cut_streams);
		$display("Checked %0d output bytes under input gaps and output stalls.", bytes_seen);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
